// ===== rtl/core/edge_stream_cluster_merger_assert.svh =====
// ----------------------------------------------------------------------------
// edge_stream_cluster_merger_assert.svh
// Assertion macros used by the cluster merger checker.
// ----------------------------------------------------------------------------
`ifndef EDGE_STREAM_CLUSTER_MERGER_ASSERT_SVH
`define EDGE_STREAM_CLUSTER_MERGER_ASSERT_SVH

// Plain clocked assertion, disabled while reset is applied
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled item keeps its value on the next cycle
`define ESC_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  `ESC_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

// ===== rtl/core/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Widths, action codes and controller/datapath bundles of the cluster merger.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int LABEL_W   = NODE_W + 1;  // MSB set means no cluster
  localparam int SIZE_W    = NODE_W + 1;
  localparam int CONN_W    = 21;
  localparam int COUNT_W   = 10;
  localparam int ACT_W     = 3;

  localparam logic [CONN_W-1:0]  MAX_CONN_RESET = CONN_W'(10);
  localparam logic [LABEL_W-1:0] LABEL_NONE     = {LABEL_W{1'b1}};

  // action codes
  localparam logic [ACT_W-1:0] ACT_NEW     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_B_JOINS = 3'd1;
  localparam logic [ACT_W-1:0] ACT_A_JOINS = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MERGE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SAME    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // clear one label/size entry
    logic in_rdy;    // edge channel ready
    logic take;      // edge accepted
    logic rd_lbl;    // read both endpoint labels
    logic rd_sz;     // read both cluster sizes
    logic apply;     // decide and write the update
    logic wr2;       // second label write of a new cluster
    logic walk;      // relabel sweep step
    logic emit;      // load the result register
  } esc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic ignore;
    logic need_wr2;
    logic need_walk;
    logic walk_done;
    logic out_free;
  } esc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/esc_if.sv =====
// ----------------------------------------------------------------------------
// esc_if
// Valid/ready channels of the cluster merger: edges, results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface esc_link_if;
  logic                      valid;
  logic                      ready;
  logic [esc_pkg::NODE_W-1:0] node_a;
  logic [esc_pkg::NODE_W-1:0] node_b;
  modport source (output valid, output node_a, output node_b, input ready);
  modport sink   (input valid, input node_a, input node_b, output ready);
endinterface

interface esc_res_if;
  logic                       valid;
  logic                       ready;
  logic [esc_pkg::ACT_W-1:0]   action;
  logic [esc_pkg::SIZE_W-1:0]  size_after;
  logic [esc_pkg::COUNT_W-1:0] cluster_count;
  modport source (output valid, output action, output size_after, output cluster_count,
                  input ready);
  modport sink   (input valid, input action, input size_after, input cluster_count,
                  output ready);
endinterface

interface esc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [esc_pkg::CONN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/esc_datapath.sv =====
// ----------------------------------------------------------------------------
// esc_datapath
// Label and size memories, counters, edge decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  esc_pkg::esc_cmd_t           cmd_i,
  output esc_pkg::esc_sts_t           sts_o,
  input  logic [esc_pkg::NODE_W-1:0]  node_a_i,
  input  logic [esc_pkg::NODE_W-1:0]  node_b_i,
  input  logic                        cfg_we_i,
  input  logic [esc_pkg::CONN_W-1:0]  cfg_data_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [esc_pkg::ACT_W-1:0]   action_o,
  output logic [esc_pkg::SIZE_W-1:0]  size_after_o,
  output logic [esc_pkg::COUNT_W-1:0] cluster_count_o
);

  localparam int NW = esc_pkg::NODE_W;
  localparam int LW = esc_pkg::LABEL_W;
  localparam int SW = esc_pkg::SIZE_W;

  // memories
  logic [LW-1:0] lbl_mem [esc_pkg::MAX_NODES];
  logic [SW-1:0] sz_mem  [esc_pkg::MAX_NODES];

  logic [LW-1:0] lbl_rd0_q, lbl_rd1_q;
  logic [SW-1:0] sz_rd0_q, sz_rd1_q;

  // edge and state registers
  logic [NW-1:0]                 a_q, b_q;
  logic [LW-1:0]                 la_q, lb_q;
  logic [esc_pkg::CONN_W-1:0]    edges_q, maxc_q;
  logic [esc_pkg::COUNT_W-1:0]   live_q;
  logic [NW-1:0]                 clr_q;
  logic [NW:0]                   k_q;
  logic                          pv_q;
  logic [NW-1:0]                 pa_q;
  logic [esc_pkg::ACT_W-1:0]     act_q;
  logic [SW-1:0]                 sz_q;
  logic                          rvalid_q;
  logic [esc_pkg::ACT_W-1:0]     ract_q;
  logic [SW-1:0]                 rsz_q;
  logic [esc_pkg::COUNT_W-1:0]   rcnt_q;

  // decision
  logic                      none_a, none_b;
  logic [esc_pkg::ACT_W-1:0] dec_act;
  logic [SW-1:0]             dec_sz;
  logic                      dec_wr2, dec_walk, live_inc, live_dec;
  logic                      dec_lbl_we, dec_sz_we;
  logic [NW-1:0]             dec_lbl_wa, dec_sz_wa;
  logic [LW-1:0]             dec_lbl_wd;

  // memory port controls
  logic          lbl_we, sz_we, lbl_re0, walk_re, walk_hit;
  logic [NW-1:0] lbl_wa, sz_wa, lbl_ra0;
  logic [LW-1:0] lbl_wd;
  logic [SW-1:0] sz_wd;

  assign none_a = la_q[LW-1];
  assign none_b = lb_q[LW-1];

  // what one edge does, from the two labels and two sizes
  always_comb begin
    dec_act    = esc_pkg::ACT_SAME;
    dec_sz     = sz_rd0_q;
    dec_wr2    = 1'b0;
    dec_walk   = 1'b0;
    live_inc   = 1'b0;
    live_dec   = 1'b0;
    dec_lbl_we = 1'b0;
    dec_lbl_wa = a_q;
    dec_lbl_wd = la_q;
    dec_sz_we  = 1'b0;
    dec_sz_wa  = la_q[NW-1:0];
    if (a_q == b_q) begin
      // self loop
      dec_sz = none_a ? '0 : sz_rd0_q;
    end else if (none_a && none_b) begin
      dec_act    = esc_pkg::ACT_NEW;
      dec_sz     = SW'(2);
      dec_wr2    = 1'b1;
      live_inc   = 1'b1;
      dec_lbl_we = 1'b1;
      dec_lbl_wd = {1'b0, a_q};
      dec_sz_we  = 1'b1;
      dec_sz_wa  = a_q;
    end else if (none_b) begin
      dec_act    = esc_pkg::ACT_B_JOINS;
      dec_sz     = sz_rd0_q + SW'(1);
      dec_lbl_we = 1'b1;
      dec_lbl_wa = b_q;
      dec_sz_we  = 1'b1;
    end else if (none_a) begin
      dec_act    = esc_pkg::ACT_A_JOINS;
      dec_sz     = sz_rd1_q + SW'(1);
      dec_lbl_we = 1'b1;
      dec_lbl_wd = lb_q;
      dec_sz_we  = 1'b1;
      dec_sz_wa  = lb_q[NW-1:0];
    end else if (la_q != lb_q) begin
      // merge: size now, labels by the sweep
      dec_act   = esc_pkg::ACT_MERGE;
      dec_sz    = sz_rd0_q + sz_rd1_q;
      dec_walk  = 1'b1;
      live_dec  = 1'b1;
      dec_sz_we = 1'b1;
    end
  end

  // sweep read and hit
  assign walk_re  = cmd_i.walk & ~k_q[NW];
  assign walk_hit = cmd_i.walk & pv_q & (lbl_rd0_q == lb_q);
  assign lbl_re0  = cmd_i.rd_lbl | walk_re;
  assign lbl_ra0  = cmd_i.walk ? k_q[NW-1:0] : a_q;

  // write port selection
  always_comb begin
    lbl_we = 1'b0;
    lbl_wa = clr_q;
    lbl_wd = esc_pkg::LABEL_NONE;
    sz_we  = 1'b0;
    sz_wa  = clr_q;
    sz_wd  = '0;
    if (cmd_i.clr_step) begin
      lbl_we = 1'b1;
      sz_we  = 1'b1;
    end else if (cmd_i.apply) begin
      lbl_we = dec_lbl_we;
      lbl_wa = dec_lbl_wa;
      lbl_wd = dec_lbl_wd;
      sz_we  = dec_sz_we;
      sz_wa  = dec_sz_wa;
      sz_wd  = dec_sz;
    end else if (cmd_i.wr2) begin
      lbl_we = 1'b1;
      lbl_wa = b_q;
      lbl_wd = {1'b0, a_q};
    end else if (cmd_i.walk) begin
      lbl_we = walk_hit;
      lbl_wa = pa_q;
      lbl_wd = la_q;
      // retire the absorbed cluster's size on the first sweep cycle
      sz_we  = (k_q == '0) & ~pv_q;
      sz_wa  = lb_q[NW-1:0];
    end
  end

  // label memory
  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    if (lbl_re0) lbl_rd0_q <= lbl_mem[lbl_ra0];
    if (cmd_i.rd_lbl) lbl_rd1_q <= lbl_mem[b_q];
  end

  // size memory
  always_ff @(posedge clk_i) begin
    if (sz_we) sz_mem[sz_wa] <= sz_wd;
    if (cmd_i.rd_sz) begin
      sz_rd0_q <= sz_mem[lbl_rd0_q[NW-1:0]];
      sz_rd1_q <= sz_mem[lbl_rd1_q[NW-1:0]];
    end
  end

  // control registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q  <= '0;
      live_q   <= '0;
      maxc_q   <= esc_pkg::MAX_CONN_RESET;
      clr_q    <= '0;
      k_q      <= '0;
      pv_q     <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) maxc_q <= cfg_data_i;
      if (cmd_i.clr_step) clr_q <= clr_q + NW'(1);
      if (cmd_i.take && !sts_o.ignore) edges_q <= edges_q + esc_pkg::CONN_W'(1);
      if (cmd_i.apply && live_inc) live_q <= live_q + esc_pkg::COUNT_W'(1);
      if (cmd_i.apply && live_dec && (live_q != '0)) live_q <= live_q - esc_pkg::COUNT_W'(1);
      if (cmd_i.apply) begin
        k_q  <= '0;
        pv_q <= 1'b0;
      end else if (cmd_i.walk) begin
        k_q  <= k_q + (NW + 1)'(walk_re);
        pv_q <= walk_re;
      end
      if (cmd_i.emit) rvalid_q <= 1'b1;
      else if (res_ready_i) rvalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      act_q <= esc_pkg::ACT_IGNORED;
      sz_q  <= '0;
    end
    if (cmd_i.rd_sz) begin
      la_q <= lbl_rd0_q;
      lb_q <= lbl_rd1_q;
    end
    if (cmd_i.apply) begin
      act_q <= dec_act;
      sz_q  <= dec_sz;
    end
    if (cmd_i.walk) pa_q <= k_q[NW-1:0];
    if (cmd_i.emit) begin
      ract_q <= act_q;
      rsz_q  <= sz_q;
      rcnt_q <= live_q;
    end
  end

  // status
  assign sts_o.clr_last  = &clr_q;
  assign sts_o.ignore    = edges_q >= maxc_q;
  assign sts_o.need_wr2  = dec_wr2;
  assign sts_o.need_walk = dec_walk;
  assign sts_o.walk_done = k_q[NW] & ~pv_q;
  assign sts_o.out_free  = ~rvalid_q | res_ready_i;

  assign res_valid_o     = rvalid_q;
  assign action_o        = ract_q;
  assign size_after_o    = rsz_q;
  assign cluster_count_o = rcnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: clearing pass, edge intake, lookups, update, relabel sweep, result.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  esc_pkg::esc_sts_t sts_i,
  output esc_pkg::esc_cmd_t cmd_o
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDL   = 3'd2;
  localparam logic [2:0] S_RDS   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;
  localparam logic [2:0] S_WALK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.in_rdy = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.ignore ? S_OUT : S_RDL;
        end
      end
      S_RDL: begin
        cmd_o.rd_lbl = 1'b1;
        state_d      = S_RDS;
      end
      S_RDS: begin
        cmd_o.rd_sz = 1'b1;
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.need_wr2) state_d = S_WR2;
        else if (sts_i.need_walk) state_d = S_WALK;
        else state_d = S_OUT;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_OUT;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/edge_stream_cluster_merger.sv =====
// ----------------------------------------------------------------------------
// edge_stream_cluster_merger
// Connected-component tracking over a stream of node-pair edges.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                 handshake
//  link_i   in   node_a, node_b                          valid & ready
//  res_o    out  action, size_after, cluster_count       valid & ready
//  cfg_i    in   data = max_connections                  valid & ready (always ready)
//
//  An ignored edge goes from intake to its result; others read labels,
//  then sizes, then update; a new cluster adds a second label write, a
//  merge the relabel sweep through one read port of the label memory,
//  one entry per cycle. After reset a clearing pass writes every label
//  and size entry, with link_i not ready; configuration writes are taken
//  meanwhile. One edge is in work at a time; a result waiting on res_o
//  does not block the next edge until that edge's own result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_stream_cluster_merger (
  input  logic        clk_i,
  input  logic        rst_ni,
  esc_link_if.sink    link_i,
  esc_res_if.source   res_o,
  esc_cfg_if.sink     cfg_i
);

  esc_pkg::esc_cmd_t cmd;
  esc_pkg::esc_sts_t sts;

  assign link_i.ready = cmd.in_rdy;
  assign cfg_i.ready  = 1'b1;

  // sequencer
  esc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (link_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories and arithmetic
  esc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .node_a_i        (link_i.node_a),
    .node_b_i        (link_i.node_b),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .action_o        (res_o.action),
    .size_after_o    (res_o.size_after),
    .cluster_count_o (res_o.cluster_count)
  );

endmodule

`default_nettype wire

// ===== rtl/core/esc_checker.sv =====
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks on the result channel of the cluster merger.
// ----------------------------------------------------------------------------
`default_nettype none

`include "edge_stream_cluster_merger_assert.svh"

module esc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [esc_pkg::ACT_W-1:0]   action_i,
  input logic [esc_pkg::SIZE_W-1:0]  size_after_i,
  input logic [esc_pkg::COUNT_W-1:0] cluster_count_i
);

  // a waiting result stays offered, unchanged
  `ESC_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")
  `ESC_ASSERT_HOLD(a_res_stable, clk_i, rst_ni, res_valid_i, res_ready_i, {action_i, size_after_i, cluster_count_i}, "result changed while stalled")

  // an ignored edge reports no cluster
  `ESC_ASSERT(a_ign_size, clk_i, rst_ni, res_valid_i && (action_i == esc_pkg::ACT_IGNORED) |-> size_after_i == '0, "ignored edge with nonzero size")

  // a new cluster has two nodes and is counted
  `ESC_ASSERT(a_new_size, clk_i, rst_ni, res_valid_i && (action_i == esc_pkg::ACT_NEW) |-> (size_after_i == 11'd2) && (cluster_count_i != '0), "new cluster result inconsistent")

  // joins and merges leave a cluster of at least three nodes
  `ESC_ASSERT(a_grow_size, clk_i, rst_ni, res_valid_i && ((action_i == esc_pkg::ACT_B_JOINS) || (action_i == esc_pkg::ACT_A_JOINS) || (action_i == esc_pkg::ACT_MERGE)) |-> (size_after_i > 11'd2), "grown cluster too small")

endmodule

bind edge_stream_cluster_merger esc_checker u_esc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .action_i        (res_o.action),
  .size_after_i    (res_o.size_after),
  .cluster_count_i (res_o.cluster_count)
);

`default_nettype wire
